[rtl/gcd_pkg.sv]
// ----------------------------------------------------------------------------
// Great circle distance package
// Shared widths, fixed-point constants, the CORDIC step angle function and
// the quadrant code used by the distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

   localparam int COORD_FRAC_BITS = 22;
   localparam int LAT_W           = 30;
   localparam int LON_W           = 31;
   localparam int RADIUS_W        = 24;
   localparam int DIST_W          = 33;

   localparam int CORDIC_STEPS = 40;
   localparam int SQRT_STEPS   = 32;
   localparam int ANG_W        = 44;   // CORDIC datapath word, Q40 signed
   localparam int RED_W        = 33;   // signed angle before range reduction
   localparam int UR_W         = 32;   // angle reduced into one full turn
   localparam int REM_W        = 30;   // remainder below a quarter turn
   localparam int RAD_W        = 41;   // quarter-turn remainder in radians Q40
   localparam int MAG_W        = 32;   // Q31 magnitude, at most one
   localparam int PROD_W       = 64;
   localparam int ROOT_W       = 32;
   localparam int RX100_W      = 31;
   localparam int HI_W         = 55;
   localparam int LO_W         = 52;

   localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
   localparam logic [63:0] DEG_TO_RAD_Q38 = (PI_Q60 >> 22) / 64'd180;

   localparam logic [RED_W-1:0] FULL_PT   = RED_W'(64'd360 << COORD_FRAC_BITS);
   localparam logic [RED_W-1:0] FULL_HALF = RED_W'(64'd360 << (COORD_FRAC_BITS + 1));
   localparam logic [UR_W-1:0]  QTR_PT    = UR_W'(64'd90 << COORD_FRAC_BITS);
   localparam logic [UR_W-1:0]  QTR_HALF  = UR_W'(64'd90 << (COORD_FRAC_BITS + 1));

   localparam logic [63:0]       ONE_Q62      = 64'h4000_0000_0000_0000;
   localparam logic [MAG_W-1:0]  ONE_Q31      = 32'h8000_0000;
   localparam logic [DIST_W-1:0] DIST_MAX_CM  = 33'd5270000000;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

   typedef logic signed [ANG_W-1:0] cordic_word_type;

   localparam cordic_word_type GAIN_INV_Q40 = 44'sd667681663043;

   typedef enum logic [1:0] {
      QUAD_FIRST,
      QUAD_SECOND,
      QUAD_THIRD,
      QUAD_FOURTH
   } quad_type;

   // Step angle atan(2^-step) in Q40. Beyond the first step it is the
   // alternating arctangent series summed in Q62, then rounded to Q40.
   function automatic cordic_word_type atan_q40(input int step);
      logic signed [63:0] sum;
      logic [63:0]        term;
      int                 s;
      sum = '0;
      if (step == 0) begin
         return cordic_word_type'(PI_Q60 >> 22);
      end
      for (int k = 0; k < 32; k++) begin
         s = step * (2 * k + 1);
         if (s <= 62) begin
            term = (64'd1 << (62 - s)) / 64'(2 * k + 1);
            if ((k & 1) != 0) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
      end
      return cordic_word_type'((sum + 64'sd2097152) >>> 22);
   endfunction

endpackage

[rtl/gcd_req_if.sv]
// ----------------------------------------------------------------------------
// Point pair channel
// Valid/ready channel carrying the two points of one distance request.
// ----------------------------------------------------------------------------
interface gcd_req_if import gcd_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] first_latitude;
   logic signed [LON_W-1:0] first_longitude;
   logic signed [LAT_W-1:0] second_latitude;
   logic signed [LON_W-1:0] second_longitude;

   modport source (
      output valid,
      output first_latitude,
      output first_longitude,
      output second_latitude,
      output second_longitude,
      input  ready
   );

   modport sink (
      input  valid,
      input  first_latitude,
      input  first_longitude,
      input  second_latitude,
      input  second_longitude,
      output ready
   );
endinterface

[rtl/gcd_rsp_if.sv]
// ----------------------------------------------------------------------------
// Distance channel
// Valid/ready channel carrying one distance word in centimeters.
// ----------------------------------------------------------------------------
interface gcd_rsp_if import gcd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance_cm;

   modport source (
      output valid,
      output distance_cm,
      input  ready
   );

   modport sink (
      input  valid,
      input  distance_cm,
      output ready
   );
endinterface

[rtl/great_circle_distance.sv]
// ----------------------------------------------------------------------------
// Great circle distance
// Haversine distance between two points, scaled by a programmable radius.
// ----------------------------------------------------------------------------
// Each word on req_if carries two points, latitude and longitude in degrees
// with 22 fractional bits. Each word on rsp_if carries the distance between
// them in centimeters, rounded and saturated at 5270000000.
// csr_wr_en writes csr_wr_data into the sphere radius in whole meters; write
// it only while no word is in flight.
// The datapath is one pipeline: range reduction, four 40-cell rotating
// CORDIC rows, the haversine products, two 32-cell square root rows, a
// 40-cell vectoring CORDIC row and the radius scaling. A new word can be
// accepted in every cycle while the skid entry is empty, so throughput is
// one word per clock when the receiver does not stall.
// The output register is backed by one skid entry. When the receiver stalls
// and another word reaches the output, the skid entry fills and req_if.ready
// drops with it; the whole pipeline then holds until the skid entry drains.
// Reset clears every valid flag and loads the radius with 6371000 m.
// ----------------------------------------------------------------------------
module great_circle_distance import gcd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [RADIUS_W-1:0] csr_wr_data,
   gcd_req_if.sink             req_if,
   gcd_rsp_if.source           rsp_if
);

   localparam int LANES      = 4;
   localparam int PIPE_DEPTH = 4 + CORDIC_STEPS + 9 + SQRT_STEPS + CORDIC_STEPS + 3;

   localparam logic [RED_W-1:0] FULL_LANE [LANES] = '{FULL_PT, FULL_PT, FULL_HALF, FULL_HALF};
   localparam logic [UR_W-1:0]  QTR_LANE  [LANES] = '{QTR_PT, QTR_PT, QTR_HALF, QTR_HALF};
   localparam int SHIFT_LANE [LANES] = '{COORD_FRAC_BITS - 2, COORD_FRAC_BITS - 2,
                                         COORD_FRAC_BITS - 1, COORD_FRAC_BITS - 1};

   function automatic cordic_word_type pick(input cordic_word_type cx,
                                           input cordic_word_type cy,
                                           input quad_type q,
                                           input logic want_sin);
      cordic_word_type c, s;
      unique case (q)
         QUAD_FIRST:  begin c = cx;  s = cy;  end
         QUAD_SECOND: begin c = -cy; s = cx;  end
         QUAD_THIRD:  begin c = -cx; s = -cy; end
         QUAD_FOURTH: begin c = cy;  s = -cx; end
      endcase
      return want_sin ? s : c;
   endfunction

   function automatic logic [MAG_W-1:0] mag_q31(input cordic_word_type v);
      logic [ANG_W-1:0] m;
      logic [ANG_W-1:0] r;
      m = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
      r = (m + ANG_W'(256)) >> 9;
      return (r > ANG_W'(ONE_Q31)) ? ONE_Q31 : r[MAG_W-1:0];
   endfunction

   // Control and configuration.
   logic                    en;
   logic [PIPE_DEPTH-1:0]   valid_ff;
   logic [RADIUS_W-1:0]     radius_ff;
   logic [RX100_W-1:0]      radius_x100_ff;
   logic                    rsp_valid_ff, skid_valid_ff;
   logic [DIST_W-1:0]       out_ff, skid_ff;

   // Front end: angles, reduction, quadrant, radians.
   logic signed [RED_W-1:0] ang_ff  [LANES];
   logic [UR_W-1:0]         ur_ff   [LANES];
   logic [REM_W-1:0]        rem_ff  [LANES];
   quad_type                quad_ff [LANES];
   logic [RAD_W-1:0]        rad_ff  [LANES];
   quad_type                quad_line_ff [CORDIC_STEPS+1][LANES];

   // Rotation rows.
   cordic_word_type rot_x [LANES][CORDIC_STEPS+1];
   cordic_word_type rot_y [LANES][CORDIC_STEPS+1];
   cordic_word_type rot_z [LANES][CORDIC_STEPS+1];

   // Haversine term.
   cordic_word_type         sel_ff [LANES];
   logic [MAG_W-1:0]        mag_ff [LANES];
   logic                    neg_ff [6];
   logic [PROD_W-1:0]       term1_ff [5];
   logic [MAG_W-1:0]        slon_ff  [4];
   logic [PROD_W-1:0]       cc_ff, mm_ff, term2_ff;
   logic [MAG_W-1:0]        m_ff, m2_ff;
   logic signed [PROD_W+1:0] hav_sum;
   logic [PROD_W-1:0]       hav_ff, comp_a_ff, comp_b_ff;

   // Square roots and vectoring row.
   logic [63:0]     sq_rem  [2][SQRT_STEPS+1];
   logic [63:0]     sq_root [2][SQRT_STEPS+1];
   cordic_word_type vec_x [CORDIC_STEPS+1];
   cordic_word_type vec_y [CORDIC_STEPS+1];
   cordic_word_type vec_z [CORDIC_STEPS+1];

   // Scaling.
   logic [ANG_W-1:0]   cang_ff;
   logic [HI_W-1:0]    hi_ff;
   logic [LO_W-1:0]    lo_ff;
   logic [HI_W:0]      dist_sum;
   logic [HI_W-20:0]   dist_raw;
   logic [DIST_W-1:0]  dist_ff;

   // The pipeline moves as one; it holds only while the skid entry is full.
   assign en           = ~skid_valid_ff;
   assign req_if.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         radius_ff <= RADIUS_RESET;
      end else begin
         if (en) begin
            valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_if.valid};
         end
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      radius_x100_ff <= RX100_W'(radius_ff * 7'd100);
   end

   // Front end.
   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff[0] <= RED_W'(req_if.first_latitude);
         ang_ff[1] <= RED_W'(req_if.second_latitude);
         ang_ff[2] <= RED_W'(req_if.second_latitude) - RED_W'(req_if.first_latitude);
         ang_ff[3] <= RED_W'(req_if.second_longitude) - RED_W'(req_if.first_longitude);
         for (int l = 0; l < LANES; l++) begin
            // One wrap is enough: every input lies within one turn of zero.
            ur_ff[l] <= ang_ff[l][RED_W-1] ? UR_W'(ang_ff[l] + FULL_LANE[l])
                                           : UR_W'(ang_ff[l]);
            if (ur_ff[l] >= QTR_LANE[l] * 32'd3) begin
               quad_ff[l] <= QUAD_FOURTH;
               rem_ff[l]  <= REM_W'(ur_ff[l] - QTR_LANE[l] * 32'd3);
            end else if (ur_ff[l] >= QTR_LANE[l] * 32'd2) begin
               quad_ff[l] <= QUAD_THIRD;
               rem_ff[l]  <= REM_W'(ur_ff[l] - QTR_LANE[l] * 32'd2);
            end else if (ur_ff[l] >= QTR_LANE[l]) begin
               quad_ff[l] <= QUAD_SECOND;
               rem_ff[l]  <= REM_W'(ur_ff[l] - QTR_LANE[l]);
            end else begin
               quad_ff[l] <= QUAD_FIRST;
               rem_ff[l]  <= REM_W'(ur_ff[l]);
            end
            rad_ff[l] <= RAD_W'((64'(rem_ff[l]) * DEG_TO_RAD_Q38) >> SHIFT_LANE[l]);
            quad_line_ff[0][l] <= quad_ff[l];
            for (int j = 1; j <= CORDIC_STEPS; j++) begin
               quad_line_ff[j][l] <= quad_line_ff[j-1][l];
            end
         end
      end
   end

   // Rotation rows: first and second latitude, half latitude and half
   // longitude differences.
   for (genvar l = 0; l < LANES; l++) begin : g_rot
      assign rot_x[l][0] = GAIN_INV_Q40;
      assign rot_y[l][0] = '0;
      assign rot_z[l][0] = {{(ANG_W-RAD_W){1'b0}}, rad_ff[l]};
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
         gcd_cordic_cell #(
            .STEP      (i),
            .VECTORING (1'b0)
         ) u_cell (
            .clock  (clock),
            .enable (en),
            .x_prev (rot_x[l][i]),
            .y_prev (rot_y[l][i]),
            .z_prev (rot_z[l][i]),
            .x_cur  (rot_x[l][i+1]),
            .y_cur  (rot_y[l][i+1]),
            .z_cur  (rot_z[l][i+1])
         );
      end
   end

   // Haversine products on magnitudes; the sign of the cosine product
   // decides whether the second term adds or subtracts.
   always_comb begin
      if (neg_ff[5]) begin
         hav_sum = $signed({2'b00, term1_ff[4]}) - $signed({2'b00, term2_ff});
      end else begin
         hav_sum = $signed({2'b00, term1_ff[4]}) + $signed({2'b00, term2_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            sel_ff[l] <= pick(rot_x[l][CORDIC_STEPS], rot_y[l][CORDIC_STEPS],
                              quad_line_ff[CORDIC_STEPS][l], l >= 2);
            mag_ff[l] <= mag_q31(sel_ff[l]);
         end
         neg_ff[0]   <= sel_ff[0][ANG_W-1] ^ sel_ff[1][ANG_W-1];
         term1_ff[0] <= PROD_W'(mag_ff[2] * mag_ff[2]);
         cc_ff       <= PROD_W'(mag_ff[0] * mag_ff[1]);
         slon_ff[0]  <= mag_ff[3];
         m_ff        <= MAG_W'((cc_ff + 64'd1073741824) >> 31);
         mm_ff       <= PROD_W'(m_ff * slon_ff[1]);
         m2_ff       <= MAG_W'((mm_ff + 64'd1073741824) >> 31);
         term2_ff    <= PROD_W'(m2_ff * slon_ff[3]);
         for (int j = 1; j < 5; j++) begin
            neg_ff[j]   <= neg_ff[j-1];
            term1_ff[j] <= term1_ff[j-1];
         end
         neg_ff[5] <= neg_ff[4];
         for (int j = 1; j < 4; j++) begin
            slon_ff[j] <= slon_ff[j-1];
         end
         if (hav_sum[PROD_W+1]) begin
            hav_ff <= '0;
         end else if (hav_sum > $signed({2'b00, ONE_Q62})) begin
            hav_ff <= ONE_Q62;
         end else begin
            hav_ff <= hav_sum[PROD_W-1:0];
         end
         comp_a_ff <= hav_ff;
         comp_b_ff <= ONE_Q62 - hav_ff;
      end
   end

   // Square roots of a and of one minus a.
   assign sq_rem[0][0]  = comp_a_ff;
   assign sq_rem[1][0]  = comp_b_ff;
   assign sq_root[0][0] = '0;
   assign sq_root[1][0] = '0;

   for (genvar r = 0; r < 2; r++) begin : g_sqrt
      for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
         gcd_sqrt_cell #(
            .STEP (i)
         ) u_cell (
            .clock     (clock),
            .enable    (en),
            .rem_prev  (sq_rem[r][i]),
            .root_prev (sq_root[r][i]),
            .rem_cur   (sq_rem[r][i+1]),
            .root_cur  (sq_root[r][i+1])
         );
      end
   end

   // Central half angle by vectoring: y is sqrt(a), x is sqrt(1 - a).
   assign vec_x[0] = {{(ANG_W-ROOT_W-9){1'b0}}, sq_root[1][SQRT_STEPS][ROOT_W-1:0], 9'b0};
   assign vec_y[0] = {{(ANG_W-ROOT_W-9){1'b0}}, sq_root[0][SQRT_STEPS][ROOT_W-1:0], 9'b0};
   assign vec_z[0] = '0;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      gcd_cordic_cell #(
         .STEP      (i),
         .VECTORING (1'b1)
      ) u_cell (
         .clock  (clock),
         .enable (en),
         .x_prev (vec_x[i]),
         .y_prev (vec_y[i]),
         .z_prev (vec_z[i]),
         .x_cur  (vec_x[i+1]),
         .y_cur  (vec_y[i+1]),
         .z_cur  (vec_z[i+1])
      );
   end

   // Scaling by the radius in centimeters, split so each multiply stays narrow.
   assign dist_sum = (HI_W+1)'(hi_ff) + (HI_W+1)'(lo_ff >> 20);
   assign dist_raw = dist_sum[HI_W:20];

   always_ff @(posedge clock) begin
      if (en) begin
         if (vec_z[CORDIC_STEPS][ANG_W-1]) begin
            cang_ff <= '0;
         end else begin
            cang_ff <= {vec_z[CORDIC_STEPS][ANG_W-2:0], 1'b0};
         end
         hi_ff   <= HI_W'(cang_ff[ANG_W-1:20] * radius_x100_ff);
         lo_ff   <= LO_W'(cang_ff[19:0] * radius_x100_ff) + (LO_W'(1) << 39);
         dist_ff <= (dist_raw > (HI_W-19)'(DIST_MAX_CM)) ? DIST_MAX_CM
                                                          : dist_raw[DIST_W-1:0];
      end
   end

   // Output register with one skid entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_if.ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_if.ready) begin
         rsp_valid_ff <= valid_ff[PIPE_DEPTH-1];
      end else if (valid_ff[PIPE_DEPTH-1]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_if.ready) begin
            out_ff <= skid_ff;
         end
      end else if (!rsp_valid_ff || rsp_if.ready) begin
         out_ff <= dist_ff;
      end else begin
         skid_ff <= dist_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.distance_cm = out_ff;

endmodule

[rtl/gcd_cordic_cell.sv]
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation of a pipelined CORDIC, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
module gcd_cordic_cell import gcd_pkg::*; #(
   parameter int STEP      = 0,
   parameter bit VECTORING = 1'b0
) (
   input  logic            clock,
   input  logic            enable,
   input  cordic_word_type x_prev,
   input  cordic_word_type y_prev,
   input  cordic_word_type z_prev,
   output cordic_word_type x_cur,
   output cordic_word_type y_cur,
   output cordic_word_type z_cur
);

   localparam cordic_word_type ATAN = atan_q40(STEP);

   cordic_word_type x_ff, y_ff, z_ff;
   cordic_word_type x_in, y_in, z_in;
   cordic_word_type x_sh, y_sh;
   logic            turn_neg;

   always_comb begin
      x_sh = x_prev >>> STEP;
      y_sh = y_prev >>> STEP;
      // Rotation drives the residual angle to zero, vectoring drives y to zero.
      turn_neg = VECTORING ? y_prev[ANG_W-1] : ~z_prev[ANG_W-1];
      if (turn_neg) begin
         x_in = x_prev - y_sh;
         y_in = y_prev + x_sh;
         z_in = z_prev - ATAN;
      end else begin
         x_in = x_prev + y_sh;
         y_in = y_prev - x_sh;
         z_in = z_prev + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_cur = x_ff;
   assign y_cur = y_ff;
   assign z_cur = z_ff;

endmodule

[rtl/gcd_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// One bit-pair step of a pipelined restoring integer square root.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell import gcd_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] rem_prev,
   input  logic [63:0] root_prev,
   output logic [63:0] rem_cur,
   output logic [63:0] root_cur
);

   localparam logic [63:0] PLACE = 64'd1 << (62 - 2 * STEP);

   logic [63:0] rem_ff, root_ff;
   logic [63:0] rem_in, root_in;
   logic [63:0] trial;

   always_comb begin
      trial = root_prev + PLACE;
      if (rem_prev >= trial) begin
         rem_in  = rem_prev - trial;
         root_in = (root_prev >> 1) + PLACE;
      end else begin
         rem_in  = rem_prev;
         root_in = root_prev >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_cur  = rem_ff;
   assign root_cur = root_ff;

endmodule
